FILE: rtl/core/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the decimal ASCII converter
// Item layout between the front and back ends, back-end states, character
// codes and sizing constants.
// ----------------------------------------------------------------------------
package itda_pkg;

	localparam int WORD_W      = 32;
	localparam int NUM_DIGITS  = 10;
	localparam int DIGIT_W     = 4;
	localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
	localparam int PTR_W       = $clog2(NUM_DIGITS);
	localparam int STEP_W      = $clog2(WORD_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// interpretation codes on func
	localparam logic FUNC_SIGNED   = 1'b0;
	localparam logic FUNC_UNSIGNED = 1'b1;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// classified item: sign flag and magnitude
	typedef struct packed {
		logic              neg;
		logic [WORD_W-1:0] mag;
	} item_t;

	// handoff from queue to back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qout_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_DIGITS
	} back_state_t;

endpackage

FILE: rtl/core/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: 32-bit integer to decimal ASCII text
// Converts a signed or unsigned word into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: value and func are taken at a clock edge with start high and
//   busy low. func = 0 reads value as two's complement, func = 1 as unsigned.
//   Output: one character per cycle on text_char with strobe high, most
//   significant first; last marks the final character. A negative number
//   begins with '-'. Zero gives the single character '0'.
//   Before the first character, a word passes the queue handoff, 32
//   shift-and-add-3 steps and a search for the leading digit. A word gives
//   1 to 11 characters. The serial BCD converter in the back end sets the
//   rate and works one word at a time, so it takes no new word until done.
//   The front end holds one word and a two-entry queue holds two more, so up
//   to three words can be accepted while a conversion runs; busy rises when
//   all of them are taken.
//   The receiver cannot stall: each character is shown for exactly one cycle.
//   Reset (arst_n low) empties the queue and returns the converter to idle;
//   nothing is kept between words.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
	import itda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [WORD_W-1:0] value,
	input  logic              func,
	output logic              strobe,
	output logic [7:0]        text_char,
	output logic              last
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	qout_t qout;

	itda_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.func      (func),
		.busy      (busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	itda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.qout      (qout)
	);

	itda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qout      (qout),
		.pop       (pop),
		.strobe    (strobe),
		.text_char (text_char),
		.last      (last)
	);

endmodule

FILE: rtl/core/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front: input accept and sign classification
// Takes a word on start, splits it into sign and magnitude and holds it in a
// stage register until the queue takes it.
// ----------------------------------------------------------------------------
module itda_front
	import itda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] value,
	input  logic              func,
	output logic              busy,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;
	item_t cls;

	// sign and magnitude; the most negative value wraps to its own magnitude
	always_comb begin
		cls.neg = (func == FUNC_SIGNED) && value[WORD_W-1];
		cls.mag = cls.neg ? (~value + {{(WORD_W-1){1'b0}}, 1'b1}) : value;
	end

	assign busy      = valid_s1 && q_full;
	assign accept    = start && !busy;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

FILE: rtl/core/itda_queue.sv
// ----------------------------------------------------------------------------
// itda_queue: short item queue between front and back ends
// Two-entry FIFO of classified items.
// ----------------------------------------------------------------------------
module itda_queue
	import itda_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output qout_t qout
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign qout.valid = (cnt_q != '0);
	assign qout.item  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && qout.valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/core/itda_back.sv
// ----------------------------------------------------------------------------
// itda_back: binary-to-BCD conversion and character emission
// Shift-and-add-3 conversion, a step to locate the leading digit,
// then an optional minus sign and one digit per cycle.
// ----------------------------------------------------------------------------
module itda_back
	import itda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  qout_t       qout,
	output logic        pop,
	output logic        strobe,
	output logic [7:0]  text_char,
	output logic        last
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [WORD_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [STEP_W-1:0] cnt_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  top;
	logic              neg_q;
	logic [DIGIT_W-1:0] digit [NUM_DIGITS];

	// digit view of the BCD register and add-3 correction per digit
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digit[i] = bcd_q[i*DIGIT_W +: DIGIT_W];
			bcd_adj[i*DIGIT_W +: DIGIT_W] = (digit[i] >= DIGIT_W'(5))
				? digit[i] + DIGIT_W'(3) : digit[i];
		end
	end

	// leading nonzero digit, zero value gives digit 0
	always_comb begin
		top = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (digit[i] != '0) begin
				top = PTR_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (qout.valid) state_d = ST_CONV;
			ST_CONV:   if (cnt_q == STEP_W'(WORD_W - 1)) state_d = ST_FIND;
			ST_FIND:   state_d = neg_q ? ST_SIGN : ST_DIGITS;
			ST_SIGN:   state_d = ST_DIGITS;
			ST_DIGITS: if (ptr_q == '0) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		strobe    = 1'b0;
		text_char = CHAR_ZERO;
		last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop = qout.valid;
			end
			ST_SIGN: begin
				strobe    = 1'b1;
				text_char = CHAR_MINUS;
			end
			ST_DIGITS: begin
				strobe    = 1'b1;
				text_char = CHAR_ZERO + {4'b0000, digit[ptr_q]};
				last      = (ptr_q == '0);
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (qout.valid) begin
					bin_q <= qout.item.mag;
					neg_q <= qout.item.neg;
					bcd_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[WORD_W-1]};
				bin_q <= {bin_q[WORD_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_FIND: begin
				ptr_q <= top;
			end
			ST_DIGITS: begin
				ptr_q <= ptr_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/itda_checker.sv
// ----------------------------------------------------------------------------
// itda_checker: port-level checks on the converter's character stream
// Character set, sign placement and unbroken character runs.
// ----------------------------------------------------------------------------
module itda_checker
	import itda_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic [7:0] text_char,
	input logic       last
);

	// only a minus sign or a decimal digit is ever emitted
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (text_char == CHAR_MINUS) ||
			((text_char >= CHAR_ZERO) && (text_char <= CHAR_ZERO + 8'd9)))
		else $error("character outside sign and digits");

	// a minus sign never ends a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (text_char == CHAR_MINUS)) |-> !last)
		else $error("minus sign flagged as last");

	// characters of one number come on consecutive cycles
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a number");

	// a digit right after the sign is never a leading zero
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (text_char == CHAR_MINUS)) |=> (text_char != CHAR_ZERO))
		else $error("leading zero after minus sign");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.strobe    (strobe),
	.text_char (text_char),
	.last      (last)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for int_to_decimal_ascii
// Sends 32-bit words in signed and unsigned mode and predicts the decimal text
// that each word gives. Every character beat is checked in order against the
// prediction. A directed set of values comes first, then random words under
// several sender gap patterns and drain pauses.
// ----------------------------------------------------------------------------
module tb;
	import itda_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_LEN   = 11;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	// one expected character beat
	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} char_beat_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [WORD_W-1:0] value;
	logic              func;
	logic              strobe;
	logic [7:0]        text_char;
	logic              last;

	char_beat_t pending_chars[$];
	int         sender_idle_pct;
	int         errors;
	int         words_sent;
	int         neg_words;
	int         chars_checked;
	int         cycles;

	int_to_decimal_ascii uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.func      (func),
		.strobe    (strobe),
		.text_char (text_char),
		.last      (last)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding",
				cycles, pending_chars.size());
			$display("** int_to_decimal_ascii: FAILED **");
			$finish;
		end
	end

	// expected text of one word, most significant character first
	function automatic void queue_decimal_text(input logic [WORD_W-1:0] w, input logic f);
		char_beat_t        b;
		logic [3:0]        digs [NUM_DIGITS];
		logic [WORD_W-1:0] mag;
		logic              neg;
		int                n;
		neg = (f == FUNC_SIGNED) && w[WORD_W-1];
		mag = neg ? (32'd0 - w) : w;
		n = 0;
		do begin
			digs[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0 && n < NUM_DIGITS);
		if (neg) begin
			b.ch  = CHAR_MINUS;
			b.lst = 1'b0;
			pending_chars.push_back(b);
		end
		for (int k = n - 1; k >= 0; k--) begin
			b.ch  = CHAR_ZERO + 8'(digs[k]);
			b.lst = (k == 0);
			pending_chars.push_back(b);
		end
	endfunction

	// accept monitor and character checker
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n) begin
			if (start && !busy) begin
				queue_decimal_text(value, func);
				words_sent++;
				if (func == FUNC_SIGNED && value[WORD_W-1])
					neg_words++;
			end
			if (strobe) begin
				if (pending_chars.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected char 0x%02h last=%0b", $realtime,
							text_char, last);
				end else begin
					want = pending_chars.pop_front();
					chars_checked++;
					if (text_char !== want.ch || last !== want.lst) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: mismatch: expected char 0x%02h last=%0b, got 0x%02h last=%0b",
								$realtime, want.ch, want.lst, text_char, last);
					end
				end
			end
		end
	end

	// send one word; optional random gap cycles before it
	task automatic send_word(input logic [WORD_W-1:0] w, input logic f);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= w;
		func  <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending and wait until every predicted character has come out
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	// random word biased toward digit-count and sign boundaries
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] p;
		p = 32'd1;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 999);
			2: return 32'd0 - $urandom_range(1, 1000);
			3: return $urandom >> $urandom_range(0, 31);
			4: begin
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			default: return $urandom_range(0, 1) ? (32'h8000_0000 + $urandom_range(0, 3))
				: (32'hFFFF_FFFF - $urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_random(input int n);
		repeat (n)
			send_word(pick_word(), 1'($urandom_range(0, 1)));
	endtask

	// boundary values in both modes
	task automatic test_directed_values();
		sender_idle_pct = 0;
		send_word(32'd0, FUNC_SIGNED);
		send_word(32'd0, FUNC_UNSIGNED);
		send_word(32'd1, FUNC_SIGNED);
		send_word(32'd9, FUNC_UNSIGNED);
		send_word(32'd10, FUNC_SIGNED);
		send_word(32'd99, FUNC_UNSIGNED);
		send_word(32'd100, FUNC_SIGNED);
		send_word(32'd999_999_999, FUNC_SIGNED);
		send_word(32'd1_000_000_000, FUNC_UNSIGNED);
		send_word(32'h7FFF_FFFF, FUNC_SIGNED);
		send_word(32'h7FFF_FFFF, FUNC_UNSIGNED);
		send_word(32'h8000_0000, FUNC_SIGNED);    // most negative
		send_word(32'h8000_0000, FUNC_UNSIGNED);
		send_word(32'h8000_0001, FUNC_SIGNED);
		send_word(32'hFFFF_FFFF, FUNC_SIGNED);    // minus one
		send_word(32'hFFFF_FFFF, FUNC_UNSIGNED);  // largest unsigned value, ten digits
		send_word(32'hFFFF_FFF6, FUNC_SIGNED);    // minus ten
		send_word(32'd4_000_000_000, FUNC_UNSIGNED);
		send_word(32'd4_000_000_000, FUNC_SIGNED);
		send_word(32'hAAAA_AAAA, FUNC_UNSIGNED);
		send_word(32'h5555_5555, FUNC_SIGNED);
		wait_drained();
	endtask

	task automatic test_random_back_to_back();
		sender_idle_pct = 0;
		send_random(30);
	endtask

	task automatic test_random_sender_gaps();
		sender_idle_pct = 57;
		send_random(30);
	endtask

	task automatic test_random_mixed_gaps();
		sender_idle_pct = 13;
		send_random(20);
	endtask

	// sender holds off until the output side is empty, twice over
	task automatic test_drain_pause();
		sender_idle_pct = 0;
		repeat (2) begin
			send_random(5);
			wait_drained();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		value           = '0;
		func            = FUNC_SIGNED;
		sender_idle_pct = 0;
		errors          = 0;
		words_sent      = 0;
		neg_words       = 0;
		chars_checked   = 0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_values();
		test_random_back_to_back();
		test_random_sender_gaps();
		test_random_mixed_gaps();
		test_drain_pause();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_chars.size() != 0) begin
			errors++;
			$display("%0d expected characters never came out", pending_chars.size());
		end
		$display("Converted %0d words (%0d negative in signed mode), %0d characters compared.",
			words_sent, neg_words, chars_checked);
		$display("Sender ran back to back, with sparse and dense gaps, and with drain pauses.");
		if (errors == 0) begin
			$display("** int_to_decimal_ascii: PASSED **");
		end else begin
			$display("%0d errors", errors);
			$display("** int_to_decimal_ascii: FAILED **");
		end
		$finish;
	end

endmodule
